>>> rtl/dsd_pkg.sv
// Shared types and constants for the DLE STX/ETX deframer.
package dsd_pkg;

  // Framing symbols
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // Field widths fixed by the stream format
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 12;
  localparam int KIND_W    = 3;
  localparam int MAXLEN_W  = 12;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  // Request types on the input stream
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_LONG    = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_IDLE_ESC  = 4'b0010,
    PH_FRAME     = 4'b0100,
    PH_FRAME_ESC = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [MAXLEN_W-1:0]  max_frame_len;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

endpackage

>>> rtl/dsd_cfg_regs.sv
// Configuration registers of the deframer: frame length limit and gap timeout.
module dsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [dsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsd_pkg::CFG_W-1:0]        cfg_data,
  output dsd_pkg::cfg_t                    cfg
);
  import dsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_len <= MAXLEN_W'(1024);
      cfg.timeout_ticks <= TIMEOUT_W'(100);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MAX_FRAME_LEN: cfg.max_frame_len <= cfg_data[MAXLEN_W-1:0];
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/dsd_core.sv
// Deframing state machine: one request per fire, at most one result.
module dsd_core #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          req_type,
  input  logic [dsd_pkg::BYTE_W-1:0]    rx_byte,
  input  dsd_pkg::cfg_t                 cfg,
  output dsd_pkg::result_t              res
);
  import dsd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [TIMEOUT_W-1:0]   GAP_MAX = {TIMEOUT_W{1'b1}};

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] byte_count, count_next;
  logic [TIMEOUT_W-1:0]   gap_count, gap_next;
  logic                   overflow, ovf_next;

  logic                   in_frame;
  logic [TIMEOUT_W-1:0]   gap_inc;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_ext, cnt_inc_ext;
  logic                   take;
  logic                   do_payload;

  assign in_frame    = (phase == PH_FRAME) || (phase == PH_FRAME_ESC);
  assign gap_inc     = (gap_count == GAP_MAX) ? gap_count : gap_count + 1'b1;
  assign cnt_inc     = (byte_count == CNT_MAX) ? byte_count : byte_count + 1'b1;
  assign cnt_ext     = CMP_W'(byte_count);
  assign cnt_inc_ext = CMP_W'(cnt_inc);
  assign take        = (cnt_ext < CMP_W'(cfg.max_frame_len)) && (byte_count != CNT_MAX);

  always_comb begin
    phase_next = phase;
    count_next = byte_count;
    gap_next   = gap_count;
    ovf_next   = overflow;
    do_payload = 1'b0;
    res        = '0;
    res.kind   = KIND_DATA;

    if (req_type == REQ_TICK) begin
      if (in_frame) begin
        if (gap_inc < cfg.timeout_ticks) begin
          gap_next = gap_inc;
        end else begin
          res.valid  = 1'b1;
          res.kind   = KIND_TIMEOUT;
          res.length = cnt_ext[LEN_W-1:0];
          res.last   = 1'b1;
          phase_next = PH_IDLE;
          count_next = '0;
          gap_next   = '0;
          ovf_next   = 1'b0;
        end
      end
    end else begin
      gap_next = '0;
      case (phase)
        PH_IDLE: begin
          if (rx_byte == SYM_DLE) phase_next = PH_IDLE_ESC;
        end
        PH_IDLE_ESC: begin
          if (rx_byte == SYM_STX) begin
            phase_next = PH_FRAME;
            count_next = '0;
            ovf_next   = 1'b0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_FRAME: begin
          if (rx_byte == SYM_DLE) phase_next = PH_FRAME_ESC;
          else do_payload = 1'b1;
        end
        PH_FRAME_ESC: begin
          phase_next = PH_FRAME;
          if (rx_byte == SYM_DLE) begin
            do_payload = 1'b1;
          end else if (rx_byte == SYM_ETX) begin
            res.valid  = 1'b1;
            res.length = cnt_ext[LEN_W-1:0];
            res.last   = 1'b1;
            if (overflow)               res.kind = KIND_LONG;
            else if (byte_count == '0)  res.kind = KIND_EMPTY;
            else                        res.kind = KIND_OK;
            phase_next = PH_IDLE;
            count_next = '0;
            ovf_next   = 1'b0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      // Escaped DLE and plain bytes both land here; the byte value is rx_byte.
      if (do_payload) begin
        count_next = cnt_inc;
        if (take) begin
          res.valid  = 1'b1;
          res.kind   = KIND_DATA;
          res.data   = rx_byte;
          res.length = cnt_inc_ext[LEN_W-1:0];
        end else begin
          ovf_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= '0;
      gap_count  <= '0;
      overflow   <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      byte_count <= count_next;
      gap_count  <= gap_next;
      overflow   <= ovf_next;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.valid && res.last |=> (phase == PH_IDLE) && (byte_count == '0))
    else $error("frame state not cleared after status result");

  a_gap_in_frame: assert property (@(posedge clk) disable iff (rst)
    (gap_count != '0) |-> (phase == PH_FRAME) || (phase == PH_FRAME_ESC))
    else $error("gap counter running outside a frame");

  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    (byte_count != '0) |-> (phase == PH_FRAME) || (phase == PH_FRAME_ESC))
    else $error("byte counter nonzero outside a frame");

endmodule

>>> rtl/dle_stx_etx_deframer.sv
// Top level of the DLE STX/ETX deframer: stream registers around the core.
//
// Input stream (s_*): one request per transfer. s_tuser selects a received
// byte (0) or one time tick (1); s_tdata carries the byte. DLE STX opens a
// frame, DLE DLE inside a frame gives one 0x10, DLE ETX closes it.
// Output stream (m_*): unstuffed payload bytes and one status per frame end
// (ok, empty, too long, timeout); m_tlast marks the status.
// Config port: cfg_wen writes cfg_data into register cfg_index (0 max frame
// length, 1 timeout in ticks); write only while the stream is quiet.
// A request waits in the input register and its result is loaded into the
// result register once free. Throughput: one request per cycle unless m_tready
// stalls, set by the state update between the input and result registers.
// Reset: synchronous, clears the frame state and the valid flags of both stream
// registers, and loads the limits 1024 bytes and 100 ticks.
// Stall: while m_tready is low the result holds; one more request waits in
// the input register, then s_tready drops until the result is taken.
module dle_stx_etx_deframer #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dsd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
  input  logic                              s_tuser,   // [0] req_type
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dsd_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] data_byte, [19:8] frame_length
  output logic [dsd_pkg::KIND_W-1:0]        m_tuser,   // [2:0] kind
  output logic                              m_tlast,
  // Configuration write port
  input  logic                              cfg_wen,
  input  logic [dsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsd_pkg::CFG_W-1:0]         cfg_data
);
  import dsd_pkg::*;

  cfg_t               cfg;
  result_t            res;

  // Input register
  logic               in_valid;
  logic               in_req;
  logic [BYTE_W-1:0]  in_byte;

  // Result register
  kind_t              out_kind;
  logic [BYTE_W-1:0]  out_data;
  logic [LEN_W-1:0]   out_len;
  logic               out_last;

  logic               fire;
  logic               s_accept;

  // Process the held request whenever the result register can take its result.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_req  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  dsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dsd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (in_req),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .res      (res)
  );

  // Drop the result once taken; load a new one when the request yields one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind <= res.kind;
      out_data <= res.data;
      out_len  <= res.length;
      out_last <= res.last;
    end
  end

  assign m_tdata = {(OUT_DATA_W - LEN_W - BYTE_W)'(0), out_len, out_data};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
